[rtl/pts_pkg.sv]
// package: shared types and constants of the process table scheduler
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;
    localparam int SLOTS_DEF = 64;
    localparam logic [2:0] CMD_CREATE = 3'd0;
    localparam logic [2:0] CMD_SLEEP  = 3'd1;
    localparam logic [2:0] CMD_WAKE   = 3'd2;
    localparam logic [2:0] CMD_SETPRI = 3'd3;
    localparam logic [2:0] CMD_SELECT = 3'd4;
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_HARD  = 2'd2;
    localparam logic [1:0] ST_SOFT  = 2'd3;
    localparam logic [1:0] RS_OK     = 2'd0;
    localparam logic [1:0] RS_INTR   = 2'd1;
    localparam logic [1:0] RS_FULL   = 2'd2;
    localparam logic [1:0] RS_NORUN  = 2'd3;
    localparam logic [6:0] BASE_RESET = 7'd100;
    localparam int PRI_MAX = 127;
    localparam int PRI_MIN = -128;

    // classified command handed from front to back
    typedef struct packed {
        logic [2:0]        cmd;
        logic [5:0]        idx;
        logic              idx_ok;
        logic [31:0]       chan;
        logic signed [7:0] pri;
        logic              refuse;
    } t_job;
endpackage
`default_nettype wire

[rtl/process_table_scheduler_core.sv]
// top level: process table scheduler with config port, front, queue and back
`timescale 1ns / 1ps
`default_nettype none
// channel   | handshake          | payload
// command   | i_valid / o_stall  | command, index, channel, priorities, usage
// result    | o_valid / i_stall  | status, slot, priority, pid, woken, resched
// config    | apb write/read     | user base priority at byte address 0
// create, wakeup and select walk the whole table in a one-slot-a-cycle scan
// sleep, set priority and unknown commands skip the scan
// reset is synchronous and active low; a clearing pass over every slot then empties the table
// the two-beat queue lets commands be taken while the back end is busy
// a held result parks the back end at its last step; the queue then fills and stalls input
module process_table_scheduler_core #(
    parameter int SLOTS = pts_pkg::SLOTS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire [2:0]         i_command,
    input  wire [5:0]         i_proc_index,
    input  wire [31:0]        i_channel,
    input  wire signed [7:0]  i_sleep_priority,
    input  wire               i_signal_pending,
    input  wire [7:0]         i_cpu_usage,
    input  wire signed [7:0]  i_nice,
    output logic              o_valid,
    input  wire               i_stall,
    output logic [1:0]        o_status,
    output logic [5:0]        o_chosen_slot,
    output logic signed [7:0] o_chosen_priority,
    output logic [15:0]       o_new_pid,
    output logic [6:0]        o_woken_count,
    output logic              o_reschedule,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [1:0]         paddr,
    input  wire [31:0]        pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import pts_pkg::*;
    logic [6:0] r_base;
    logic w_full, w_push, w_pop, w_empty;
    t_job w_in_job, w_out_job;

    // config register, single entry
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {25'd0, r_base} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_base <= BASE_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0) r_base <= pwdata[6:0];
    end

    pts_front #(.SLOTS(SLOTS)) u_front (
        .i_valid, .o_stall, .i_command, .i_proc_index,
        .i_channel, .i_sleep_priority, .i_signal_pending, .i_cpu_usage, .i_nice,
        .i_base(r_base), .i_q_full(w_full), .o_q_push(w_push), .o_q_job(w_in_job)
    );

    pts_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_job(w_in_job), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_job(w_out_job)
    );

    pts_back #(.SLOTS(SLOTS)) u_back (
        .i_clk, .i_rst_n, .i_q_empty(w_empty), .i_job(w_out_job), .o_q_pop(w_pop),
        .i_base(r_base), .o_valid, .i_stall, .o_status, .o_chosen_slot,
        .o_chosen_priority, .o_new_pid, .o_woken_count, .o_reschedule
    );
endmodule
`default_nettype wire

[rtl/pts_front.sv]
// front: accepts command beats, classifies them, computes set priority values
`timescale 1ns / 1ps
`default_nettype none
module pts_front #(
    parameter int SLOTS = pts_pkg::SLOTS_DEF
) (
    input  wire              i_valid,
    output logic             o_stall,
    input  wire [2:0]        i_command,
    input  wire [5:0]        i_proc_index,
    input  wire [31:0]       i_channel,
    input  wire signed [7:0] i_sleep_priority,
    input  wire              i_signal_pending,
    input  wire [7:0]        i_cpu_usage,
    input  wire signed [7:0] i_nice,
    input  wire [6:0]        i_base,
    input  wire              i_q_full,
    output logic             o_q_push,
    output pts_pkg::t_job    o_q_job
);
    import pts_pkg::*;
    logic signed [9:0] w_sum;
    logic signed [7:0] w_sat;

    assign o_stall = i_q_full;
    assign o_q_push = i_valid && !i_q_full;

    always_comb begin
        w_sum = $signed({6'd0, i_cpu_usage[7:4]}) + $signed({3'd0, i_base})
              + 10'(i_nice);
        if (w_sum > 10'sd127) w_sat = 8'sd127;
        else if (w_sum < -10'sd128) w_sat = -8'sd128;
        else w_sat = w_sum[7:0];
        o_q_job.cmd    = i_command;
        o_q_job.idx    = i_proc_index;
        o_q_job.idx_ok = {26'd0, i_proc_index} < SLOTS;
        o_q_job.chan   = i_channel;
        o_q_job.pri    = (i_command == CMD_SETPRI) ? w_sat : i_sleep_priority;
        o_q_job.refuse = !i_sleep_priority[7] && i_signal_pending;
    end
endmodule
`default_nettype wire

[rtl/pts_queue.sv]
// queue: two entry fifo between front and back
`timescale 1ns / 1ps
`default_nettype none
module pts_queue (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  pts_pkg::t_job i_job,
    output logic          o_full,
    input  wire           i_pop,
    output logic          o_empty,
    output pts_pkg::t_job o_job
);
    import pts_pkg::*;
    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

[rtl/pts_back.sv]
// back: slot table and scan sequencer, one slot per cycle
`timescale 1ns / 1ps
`default_nettype none
module pts_back #(
    parameter int SLOTS = pts_pkg::SLOTS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_q_empty,
    input  pts_pkg::t_job     i_job,
    output logic              o_q_pop,
    input  wire [6:0]         i_base,
    output logic              o_valid,
    input  wire               i_stall,
    output logic [1:0]        o_status,
    output logic [5:0]        o_chosen_slot,
    output logic signed [7:0] o_chosen_priority,
    output logic [15:0]       o_new_pid,
    output logic [6:0]        o_woken_count,
    output logic              o_reschedule
);
    import pts_pkg::*;
    localparam int IW = $clog2(SLOTS);
    localparam logic [1:0] S_CLEAR = 2'd0, S_IDLE = 2'd1, S_SCAN = 2'd2, S_DONE = 2'd3;

    // one table word per slot
    typedef struct packed {
        logic [1:0]        st;
        logic signed [7:0] pri;
        logic [31:0]       chan;
    } t_slot;

    t_slot r_mem [SLOTS];
    t_slot r_rd;
    logic [1:0] r_state;
    t_job r_job;
    logic [IW:0] r_i;
    logic r_found;
    logic [IW-1:0] r_best;
    logic signed [7:0] r_bpri;
    logic [6:0] r_woken;
    logic [15:0] r_pid;
    logic signed [7:0] r_cpri;
    logic r_resched;
    logic r_valid;
    logic [1:0] r_status;
    logic [5:0] r_slot;
    logic signed [7:0] r_opri;
    logic [15:0] r_new_pid;
    logic [6:0] r_woken_count;
    logic r_out_resched;

    logic [IW-1:0] w_i;
    logic [IW-1:0] w_ix;
    logic w_last;
    logic w_scan_cmd;
    logic w_out_free;
    logic signed [7:0] w_base;
    logic w_create_hit;
    logic w_wake_hit;
    logic w_select_hit;
    logic w_ren;
    logic [IW-1:0] w_raddr;
    logic w_we;
    logic [IW-1:0] w_waddr;
    t_slot w_wdata;
    logic [1:0] w_status;
    logic [5:0] w_slot;
    logic signed [7:0] w_pri;
    logic [15:0] w_pid;
    logic w_resched;

    assign w_i = r_i[IW-1:0];
    assign w_ix = IW'(r_job.idx);
    assign w_last = r_i == (IW+1)'(SLOTS - 1);
    assign w_scan_cmd = r_job.cmd == CMD_CREATE || r_job.cmd == CMD_WAKE
                     || r_job.cmd == CMD_SELECT;
    assign w_out_free = !r_valid || !i_stall;
    assign w_base = $signed({1'b0, i_base});
    // r_rd holds the word of slot w_i while scanning
    assign w_create_hit = r_job.cmd == CMD_CREATE && !r_found && r_rd.st == ST_EMPTY;
    assign w_wake_hit = r_job.cmd == CMD_WAKE && r_job.chan != 32'd0
                     && (r_rd.st == ST_HARD || r_rd.st == ST_SOFT)
                     && r_rd.chan == r_job.chan;
    assign w_select_hit = r_job.cmd == CMD_SELECT && r_rd.st == ST_RUN
                       && (!r_found || r_rd.pri < r_bpri);
    assign o_q_pop = r_state == S_IDLE && !i_q_empty;

    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_chosen_slot = r_slot;
    assign o_chosen_priority = r_opri;
    assign o_new_pid = r_new_pid;
    assign o_woken_count = r_woken_count;
    assign o_reschedule = r_out_resched;

    // table port control and result of the last step
    always_comb begin
        w_ren = 1'b0;
        w_raddr = '0;
        w_we = 1'b0;
        w_waddr = w_i;
        w_wdata = '0;
        w_status = RS_OK;
        w_slot = 6'd0;
        w_pri = 8'sd0;
        w_pid = 16'd0;
        w_resched = r_resched;
        unique case (r_state)
            S_CLEAR: w_we = 1'b1;
            S_IDLE: if (o_q_pop) begin
                w_ren = 1'b1;
                if (i_job.cmd == CMD_SLEEP || i_job.cmd == CMD_SETPRI)
                    w_raddr = IW'(i_job.idx);
            end
            S_SCAN: begin
                if (w_scan_cmd && !w_last) begin
                    w_ren = 1'b1;
                    w_raddr = w_i + 1'b1;
                end
                if (w_wake_hit) begin
                    w_we = 1'b1;
                    w_wdata = {ST_RUN, r_rd.pri, 32'd0};
                end
            end
            S_DONE: if (w_out_free) begin
                unique case (r_job.cmd)
                    CMD_CREATE: if (!r_found) w_status = RS_FULL;
                    else begin
                        w_we = 1'b1;
                        w_waddr = r_best;
                        w_wdata = {ST_RUN, w_base, 32'd0};
                        w_slot = 6'(r_best);
                        w_pri = w_base;
                        w_pid = r_pid + 16'd1;
                    end
                    CMD_SLEEP: if (r_job.idx_ok && r_rd.st != ST_EMPTY) begin
                        if (r_job.refuse) w_status = RS_INTR;
                        else begin
                            w_we = 1'b1;
                            w_waddr = w_ix;
                            w_wdata = {(r_job.pri[7] ? ST_HARD : ST_SOFT), r_job.pri,
                                       r_job.chan};
                        end
                    end
                    CMD_SETPRI: begin
                        w_pri = r_job.pri;
                        if (r_job.idx_ok) begin
                            w_we = 1'b1;
                            w_waddr = w_ix;
                            w_wdata = {r_rd.st, r_job.pri, r_rd.chan};
                            if (r_job.pri > r_cpri) w_resched = 1'b1;
                        end
                    end
                    CMD_SELECT: if (!r_found) w_status = RS_NORUN;
                    else begin
                        w_slot = 6'(r_best);
                        w_pri = r_bpri;
                        w_resched = 1'b0;
                    end
                    default: ;
                endcase
            end
        endcase
    end

    // slot table, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (w_ren) r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_i <= '0;
            r_job <= '0;
            r_found <= 1'b0;
            r_best <= '0;
            r_bpri <= 8'sd0;
            r_woken <= 7'd0;
            r_pid <= 16'd0;
            r_cpri <= 8'sd0;
            r_resched <= 1'b0;
            r_valid <= 1'b0;
            r_status <= RS_OK;
            r_slot <= 6'd0;
            r_opri <= 8'sd0;
            r_new_pid <= 16'd0;
            r_woken_count <= 7'd0;
            r_out_resched <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_valid <= 1'b1;
                r_status <= w_status;
                r_slot <= w_slot;
                r_opri <= w_pri;
                r_new_pid <= w_pid;
                r_woken_count <= r_woken;
                r_out_resched <= w_resched;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (w_last) r_state <= S_IDLE;
                    r_i <= r_i + 1'b1;
                end
                S_IDLE: if (o_q_pop) begin
                    r_job <= i_job;
                    r_i <= '0;
                    r_found <= 1'b0;
                    r_woken <= 7'd0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // one slot visited per cycle
                    if (w_create_hit || w_select_hit) begin
                        r_found <= 1'b1;
                        r_best <= w_i;
                    end
                    if (w_select_hit) r_bpri <= r_rd.pri;
                    if (w_wake_hit) begin
                        r_woken <= r_woken + 7'd1;
                        if (r_rd.pri < r_cpri) r_resched <= 1'b1;
                    end
                    if (w_last || !w_scan_cmd) r_state <= S_DONE;
                    r_i <= r_i + 1'b1;
                end
                S_DONE: if (w_out_free) begin
                    r_resched <= w_resched;
                    if (r_job.cmd == CMD_CREATE && r_found) r_pid <= w_pid;
                    if (r_job.cmd == CMD_SELECT && r_found) r_cpri <= r_bpri;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[sim/pts_result_checker.sv]
// result checker: predicts the scheduler's results and compares every result beat
`timescale 1ns / 1ps
module pts_result_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  wire               o_stall,
    input  wire [2:0]         i_command,
    input  wire [5:0]         i_proc_index,
    input  wire [31:0]        i_channel,
    input  wire signed [7:0]  i_sleep_priority,
    input  wire               i_signal_pending,
    input  wire [7:0]         i_cpu_usage,
    input  wire signed [7:0]  i_nice,
    input  wire               o_valid,
    input  wire               i_stall,
    input  wire [1:0]         o_status,
    input  wire [5:0]         o_chosen_slot,
    input  wire signed [7:0]  o_chosen_priority,
    input  wire [15:0]        o_new_pid,
    input  wire [6:0]         o_woken_count,
    input  wire               o_reschedule,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [1:0]         paddr,
    input  wire [31:0]        pwdata,
    input  wire               pready,
    output int                o_errors,
    output int                o_pending,
    output int                o_results
);
    import pts_pkg::*;

    typedef struct {
        logic [1:0]        status;
        logic [5:0]        slot;
        logic signed [7:0] pri;
        logic [15:0]       pid;
        logic [6:0]        woken;
        logic              resched;
    } t_sched_result;

    t_sched_result     awaited_results[$];

    logic [1:0]        tbl_status [64];
    logic signed [7:0] tbl_pri    [64];
    logic [31:0]       tbl_chan   [64];
    logic [15:0]       pid_count;
    logic signed [7:0] cur_pri;
    logic              resched;
    logic [6:0]        base_pri;

    initial begin
        o_errors  = 0;
        o_results = 0;
    end

    assign o_pending = awaited_results.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
                 o_results);
        o_errors++;
    endtask

    task automatic predict_command();
        t_sched_result r;
        int            p;
        int            found;
        r = '{default: '0};
        case (i_command)
            CMD_CREATE: begin
                found = -1;
                for (int i = 0; i < 64; i++)
                    if (found < 0 && tbl_status[i] == ST_EMPTY) found = i;
                if (found < 0) begin
                    r.status = RS_FULL;
                end else begin
                    tbl_status[found] = ST_RUN;
                    tbl_pri[found]    = $signed({1'b0, base_pri});
                    tbl_chan[found]   = '0;
                    pid_count++;
                    r.slot = found[5:0];
                    r.pri  = $signed({1'b0, base_pri});
                    r.pid  = pid_count;
                end
            end
            CMD_SLEEP: begin
                if (tbl_status[i_proc_index] != ST_EMPTY) begin
                    if (i_sleep_priority >= 0 && i_signal_pending) begin
                        r.status = RS_INTR;
                    end else begin
                        tbl_chan[i_proc_index]   = i_channel;
                        tbl_status[i_proc_index] = (i_sleep_priority < 0) ? ST_HARD : ST_SOFT;
                        tbl_pri[i_proc_index]    = i_sleep_priority;
                    end
                end
            end
            CMD_WAKE: begin
                if (i_channel != 0) begin
                    for (int i = 0; i < 64; i++) begin
                        if ((tbl_status[i] == ST_HARD || tbl_status[i] == ST_SOFT) &&
                            tbl_chan[i] == i_channel) begin
                            tbl_chan[i]   = '0;
                            tbl_status[i] = ST_RUN;
                            if (tbl_pri[i] < cur_pri) resched = 1'b1;
                            r.woken++;
                        end
                    end
                end
            end
            CMD_SETPRI: begin
                p = int'(i_cpu_usage >> 4) + int'(base_pri) + int'(i_nice);
                if (p > PRI_MAX) p = PRI_MAX;
                if (p < PRI_MIN) p = PRI_MIN;
                r.pri = p[7:0];
                if (p > int'(cur_pri)) resched = 1'b1;
                tbl_pri[i_proc_index] = p[7:0];
            end
            CMD_SELECT: begin
                found = -1;
                for (int i = 0; i < 64; i++)
                    if (tbl_status[i] == ST_RUN && (found < 0 || tbl_pri[i] < tbl_pri[found]))
                        found = i;
                if (found < 0) begin
                    r.status = RS_NORUN;
                end else begin
                    cur_pri = tbl_pri[found];
                    resched = 1'b0;
                    r.slot  = found[5:0];
                    r.pri   = tbl_pri[found];
                end
            end
            default: ;
        endcase
        r.resched = resched;
        awaited_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_sched_result w;
        if (!i_rst_n) begin
            for (int i = 0; i < 64; i++) begin
                tbl_status[i] = ST_EMPTY;
                tbl_pri[i]    = '0;
                tbl_chan[i]   = '0;
            end
            pid_count = '0;
            cur_pri   = '0;
            resched   = 1'b0;
            base_pri  = BASE_RESET;
        end else begin
            if (psel && penable && pwrite && pready && paddr == 2'd0)
                base_pri = pwdata[6:0];
            if (i_valid && !o_stall)
                predict_command();
            if (o_valid && !i_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("result beat with nothing awaited");
                    o_errors++;
                end else begin
                    w = awaited_results.pop_front();
                    if (o_status != w.status) report_mismatch("status", o_status, w.status);
                    if (o_chosen_slot != w.slot)
                        report_mismatch("chosen_slot", o_chosen_slot, w.slot);
                    if (o_chosen_priority != w.pri)
                        report_mismatch("chosen_priority", o_chosen_priority, w.pri);
                    if (o_new_pid != w.pid) report_mismatch("new_pid", o_new_pid, w.pid);
                    if (o_woken_count != w.woken)
                        report_mismatch("woken_count", o_woken_count, w.woken);
                    if (o_reschedule != w.resched)
                        report_mismatch("reschedule", o_reschedule, w.resched);
                end
                o_results++;
            end
        end
    end
endmodule

[sim/process_table_scheduler_core_tb.sv]
// testbench top: stimulus, config writes, idling and verdict for the scheduler core
`timescale 1ns / 1ps
module process_table_scheduler_core_tb;
    import pts_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 80;   // longer than a full slot scan

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [2:0]        i_command = '0;
    logic [5:0]        i_proc_index = '0;
    logic [31:0]       i_channel = '0;
    logic signed [7:0] i_sleep_priority = '0;
    logic              i_signal_pending = 1'b0;
    logic [7:0]        i_cpu_usage = '0;
    logic signed [7:0] i_nice = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        o_status;
    logic [5:0]        o_chosen_slot;
    logic signed [7:0] o_chosen_priority;
    logic [15:0]       o_new_pid;
    logic [6:0]        o_woken_count;
    logic              o_reschedule;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [1:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    int errors;
    int pending;
    int results;
    int cycles = 0;
    int beats_sent = 0;
    int settings_seen = 1;
    bit calm = 1'b0;        // last stretch: no idling on either side
    bit long_hold = 1'b0;   // asks the receiver for one long hold-off

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    process_table_scheduler_core u_dut (.*);

    pts_result_checker u_chk (.*, .o_errors(errors), .o_pending(pending),
                              .o_results(results));

    // generous ceiling on the whole run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results awaited", cycles, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver side: random stall bursts, one long hold-off on request
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_stall <= 1'b1;
                n = 400;
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                n = $urandom_range(1, 11);
            end else begin
                i_stall <= 1'b0;
                n = calm ? 1 : $urandom_range(1, 25);
            end
            repeat (n) @(posedge i_clk);
        end
    end

    // apb write: setup beat, access beat, register taken at the access edge
    task automatic write_base(input logic [6:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'd0;
        pwdata  <= {25'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_seen++;
    endtask

    // sender holds until every awaited result is back, then lets the back end settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // offer one command beat and hold it until taken; maybe idle afterwards
    task automatic send_cmd(input logic [2:0] cmd, input logic [5:0] idx,
                            input logic [31:0] chan, input logic signed [7:0] spri,
                            input logic sig, input logic [7:0] cpu,
                            input logic signed [7:0] nice);
        i_valid          <= 1'b1;
        i_command        <= cmd;
        i_proc_index     <= idx;
        i_channel        <= chan;
        i_sleep_priority <= spri;
        i_signal_pending <= sig;
        i_cpu_usage      <= cpu;
        i_nice           <= nice;
        do @(posedge i_clk); while (o_stall);
        beats_sent++;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_channel();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    // random beat; create_weight steers how fast the table fills
    task automatic send_random(input int create_weight);
        int          roll;
        logic [2:0]  cmd;
        roll = $urandom_range(0, 99);
        if (roll < create_weight)             cmd = CMD_CREATE;
        else if (roll < create_weight + 30)   cmd = CMD_SLEEP;
        else if (roll < create_weight + 50)   cmd = CMD_WAKE;
        else if (roll < create_weight + 65)   cmd = CMD_SETPRI;
        else if (roll < 96)                   cmd = CMD_SELECT;
        else                                  cmd = 3'($urandom_range(5, 7));
        send_cmd(cmd, 6'($urandom_range(0, 63)), pick_channel(), 8'($urandom()),
                 1'($urandom_range(0, 1)), 8'($urandom()), 8'($urandom()));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, refusals, channel zero, unknown commands
        send_cmd(CMD_SELECT, 6'd0, 32'd0, 8'sd0, 1'b0, 8'd0, 8'sd0);     // nothing runnable
        send_cmd(CMD_SLEEP, 6'd5, 32'd7, 8'sd3, 1'b0, 8'd0, 8'sd0);      // empty slot, ignored
        send_cmd(CMD_CREATE, 6'd0, 32'd0, 8'sd0, 1'b0, 8'd0, 8'sd0);
        send_cmd(CMD_CREATE, 6'd0, 32'd0, 8'sd0, 1'b0, 8'd0, 8'sd0);
        send_cmd(CMD_CREATE, 6'd0, 32'd0, 8'sd0, 1'b0, 8'd0, 8'sd0);
        send_cmd(CMD_SELECT, 6'd0, 32'd0, 8'sd0, 1'b0, 8'd0, 8'sd0);
        send_cmd(CMD_SLEEP, 6'd1, 32'd9, 8'sd20, 1'b1, 8'd0, 8'sd0);     // soft sleep refused
        send_cmd(CMD_SLEEP, 6'd1, 32'd9, -8'sd128, 1'b1, 8'd0, 8'sd0);   // hard sleep, signal ignored
        send_cmd(CMD_SLEEP, 6'd2, 32'hFFFF_FFFF, 8'sd127, 1'b0, 8'd0, 8'sd0);
        send_cmd(CMD_SLEEP, 6'd0, 32'd0, 8'sd5, 1'b0, 8'd0, 8'sd0);      // parked on channel zero
        send_cmd(CMD_WAKE, 6'd0, 32'd0, 8'sd0, 1'b0, 8'd0, 8'sd0);       // channel zero ignored
        send_cmd(CMD_WAKE, 6'd0, 32'd9, 8'sd0, 1'b0, 8'd0, 8'sd0);       // below current, resched
        send_cmd(CMD_WAKE, 6'd0, 32'hFFFF_FFFF, 8'sd0, 1'b0, 8'd0, 8'sd0);
        send_cmd(CMD_SELECT, 6'd0, 32'd0, 8'sd0, 1'b0, 8'd0, 8'sd0);
        send_cmd(CMD_SETPRI, 6'd63, 32'd0, 8'sd0, 1'b0, 8'd255, 8'sd127); // saturates high
        send_cmd(3'd5, 6'd0, 32'd0, 8'sd0, 1'b0, 8'd0, 8'sd0);
        send_cmd(3'd7, 6'd63, 32'hFFFF_FFFF, -8'sd1, 1'b1, 8'd255, -8'sd1);
        wait_idle();
        write_base(7'd0);
        send_cmd(CMD_SETPRI, 6'd2, 32'd0, 8'sd0, 1'b0, 8'd0, -8'sd128);   // lands exactly on the low limit
        send_cmd(CMD_CREATE, 6'd0, 32'd0, 8'sd0, 1'b0, 8'd0, 8'sd0);
        send_cmd(CMD_SELECT, 6'd0, 32'd0, 8'sd0, 1'b0, 8'd0, 8'sd0);
        wait_idle();

        // random phases over several base settings; the table fills during the first
        write_base(7'd127);
        for (int k = 0; k < 450; k++) begin
            if (k == 150) long_hold = 1'b1;   // block fills and stalls its input
            send_random(30);
        end
        wait_idle();
        write_base(7'd0);
        for (int k = 0; k < 450; k++) send_random(10);
        wait_idle();
        write_base(7'($urandom_range(0, 127)));
        for (int k = 0; k < 450; k++) send_random(10);
        wait_idle();
        write_base(7'd64);
        for (int k = 0; k < 300; k++) send_random(10);
        calm = 1'b1;
        for (int k = 0; k < 200; k++) send_random(10);
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d command beats and %0d result beats", beats_sent, results);
        $display("across %0d base priority settings, table full and idle-port stalls",
                 settings_seen);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
